@@ rtl/core/lsps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor PID steering: shared package
// Field widths, register indexes, reset values and the command and status
// words that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsps_pkg;

	// Fixed widths of the ports and of the controller state.
	localparam int IN_W       = 8;
	localparam int GAIN_W     = 16;
	localparam int DRIVE_W    = 24;
	localparam int ERR_W      = 16;
	localparam int WIN_W      = 15;
	localparam int INTEG_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Defaults for the top level parameters.
	localparam int DEF_NUM_SENSORS = 8;
	localparam int DEF_FRAC_BITS   = 8;

	// Register reset values.
	localparam logic signed [GAIN_W-1:0]  RST_GAIN_P    = 16'sd384;
	localparam logic signed [GAIN_W-1:0]  RST_GAIN_I    = 16'sd3;
	localparam logic signed [GAIN_W-1:0]  RST_GAIN_D    = 16'sd0;
	localparam logic signed [DRIVE_W-1:0] RST_DRIVE_MAX = 24'sd38400;
	localparam logic signed [DRIVE_W-1:0] RST_DRIVE_MIN = -24'sd38400;
	localparam logic [WIN_W-1:0]          RST_WINDOW    = 15'd768;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P    = 3'd0,
		CFG_GAIN_I    = 3'd1,
		CFG_GAIN_D    = 3'd2,
		CFG_DRIVE_MAX = 3'd3,
		CFG_DRIVE_MIN = 3'd4,
		CFG_WINDOW    = 3'd5
	} cfg_reg_t;

	// Operand selection of the shared divider.
	typedef enum logic {
		DIV_SEL_ERR   = 1'b0,
		DIV_SEL_INTEG = 1'b1
	} div_sel_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [1:0] {
		MUL_SEL_P = 2'd0,
		MUL_SEL_I = 2'd1,
		MUL_SEL_D = 2'd2
	} mul_sel_t;

	// Accumulator operation.
	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_op_t;

	// One configuration write.
	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic     load;
		logic     div_start;
		div_sel_t div_sel;
		logic     take_err;
		logic     integ_vs;
		logic     integ_gain;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     round;
		logic     finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

endpackage

@@ rtl/core/lsps_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor PID steering: unsigned divider
// Restoring division, two quotient bits per cycle. The quotient is shifted
// into the numerator register and is valid when done pulses.
// ----------------------------------------------------------------------------
module lsps_divider #(
	parameter int NUM_W = 26,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int STEPS = NUM_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [DEN_W:0]   trial0, trial1, diff0, diff1;
	logic             ge0, ge1;
	logic [DEN_W-1:0] rem1, rem2;

	// Two restoring steps, the second one working on the first's remainder.
	always_comb begin
		trial0 = {rem_q, num_q[NUM_W-1]};
		diff0  = trial0 - {1'b0, den_q};
		ge0    = trial0 >= {1'b0, den_q};
		rem1   = ge0 ? diff0[DEN_W-1:0] : trial0[DEN_W-1:0];
		trial1 = {rem1, num_q[NUM_W-2]};
		diff1  = trial1 - {1'b0, den_q};
		ge1    = trial1 >= {1'b0, den_q};
		rem2   = ge1 ? diff1[DEN_W-1:0] : trial1[DEN_W-1:0];
	end

	// Sequencing of the iterations.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(STEPS);
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operand and partial remainder registers.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[NUM_W-3:0], ge0, ge1};
			rem_q <= rem2;
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

@@ rtl/core/lsps_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor PID steering: datapath
// Configuration registers, sensor weighting, error and integrator update,
// the shared multiplier with its accumulator, and the result register.
// ----------------------------------------------------------------------------
module lsps_datapath #(
	parameter int NUM_SENSORS = lsps_pkg::DEF_NUM_SENSORS,
	parameter int FRAC_BITS   = lsps_pkg::DEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lsps_pkg::cmd_t                    cmd,
	output lsps_pkg::status_t                 status,
	input  lsps_pkg::cfg_wr_t                 cfg,
	input  logic [lsps_pkg::IN_W-1:0]         sensor_bits,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [lsps_pkg::DRIVE_W-1:0] drive,
	output logic signed [lsps_pkg::ERR_W-1:0] position_error,
	output logic                              line_lost
);

	import lsps_pkg::*;

	// Sensors that the input word actually carries.
	localparam int IN_N      = (NUM_SENSORS < IN_W) ? NUM_SENSORS : IN_W;
	localparam int SUM_MAX   = 10 * (NUM_SENSORS - 1) * IN_N;
	localparam int SUM_W     = $clog2(SUM_MAX + 1) + 1;
	localparam int CNT_W     = $clog2(IN_N + 1);
	localparam int MAG5_W    = 18;
	localparam int NUM1_W    = SUM_W - 1 + FRAC_BITS;
	localparam int NUM2_W    = MAG5_W + FRAC_BITS;
	localparam int NW_RAW    = (NUM1_W > NUM2_W) ? NUM1_W : NUM2_W;
	localparam int NW        = NW_RAW + (NW_RAW % 2);
	localparam int DW        = $clog2((2 ** (ERR_W - 1)) + 5 * (2 ** FRAC_BITS) + 1);
	localparam int Q2_W      = FRAC_BITS + 3;
	localparam int PROD_W    = GAIN_W + INTEG_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int DRV_W     = ACC_W - FRAC_BITS;

	localparam logic [NW-1:0]    ERR_POS_LIM = NW'((2 ** (ERR_W - 1)) - 1);
	localparam logic [NW-1:0]    ERR_NEG_LIM = NW'(2 ** (ERR_W - 1));
	localparam logic [DW-1:0]    FIVE_ONE    = DW'(5 * (2 ** FRAC_BITS));
	localparam logic signed [ACC_W-1:0] BIAS = ACC_W'((2 ** FRAC_BITS) - 1);
	localparam logic signed [INTEG_W+1:0] SAT_HI = {3'b000, {(INTEG_W - 1){1'b1}}};
	localparam logic signed [INTEG_W+1:0] SAT_LO = {3'b111, {(INTEG_W - 1){1'b0}}};

	function automatic logic signed [INTEG_W-1:0] sat_integ(
		input logic signed [INTEG_W+1:0] v
	);
		if (v > SAT_HI)
			return INTEG_W'(SAT_HI);
		else if (v < SAT_LO)
			return INTEG_W'(SAT_LO);
		else
			return v[INTEG_W-1:0];
	endfunction

	// Configuration registers.
	logic signed [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
	logic signed [DRIVE_W-1:0] drive_max_q, drive_min_q;
	logic [WIN_W-1:0]          window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= RST_GAIN_P;
			gain_i_q    <= RST_GAIN_I;
			gain_d_q    <= RST_GAIN_D;
			drive_max_q <= RST_DRIVE_MAX;
			drive_min_q <= RST_DRIVE_MIN;
			window_q    <= RST_WINDOW;
		end else if (cfg.en) begin
			case (cfg_reg_t'(cfg.index))
				CFG_GAIN_P:    gain_p_q    <= cfg.data[GAIN_W-1:0];
				CFG_GAIN_I:    gain_i_q    <= cfg.data[GAIN_W-1:0];
				CFG_GAIN_D:    gain_d_q    <= cfg.data[GAIN_W-1:0];
				CFG_DRIVE_MAX: drive_max_q <= cfg.data[DRIVE_W-1:0];
				CFG_DRIVE_MIN: drive_min_q <= cfg.data[DRIVE_W-1:0];
				CFG_WINDOW:    window_q    <= cfg.data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Weighted sum and count of the active sensors.
	logic signed [SUM_W-1:0] sum_c;
	logic [CNT_W-1:0]        cnt_c;

	always_comb begin
		sum_c = '0;
		cnt_c = '0;
		for (int i = 0; i < IN_N; i++) begin
			if (sensor_bits[i]) begin
				sum_c = sum_c + SUM_W'((2 * i - (NUM_SENSORS - 1)) * 10);
				cnt_c = cnt_c + CNT_W'(1);
			end
		end
	end

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= sum_c;
			cnt_q <= cnt_c;
		end
	end

	// Divider operands: the mean of the weights, then the integration step.
	logic [SUM_W-1:0]  sum_abs;
	logic [MAG5_W-1:0] mag5;
	logic [NW-1:0]     div_num;
	logic [DW-1:0]     div_den;
	logic [NW-1:0]     quot;
	logic              div_done;
	logic signed [ERR_W-1:0] e_q;
	logic [ERR_W-1:0]        mag_q;

	always_comb begin
		sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		mag5    = {2'b00, mag_q} + {mag_q, 2'b00};
		case (cmd.div_sel)
			DIV_SEL_ERR: begin
				div_num = NW'({sum_abs[SUM_W-2:0], {FRAC_BITS{1'b0}}});
				div_den = DW'(cnt_q);
			end
			DIV_SEL_INTEG: begin
				div_num = NW'({mag5, {FRAC_BITS{1'b0}}});
				div_den = DW'(mag_q) + FIVE_ONE;
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	lsps_divider #(
		.NUM_W(NW),
		.DEN_W(DW)
	) u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (quot)
	);

	// Error from the quotient: sign of the sum, saturated to the error width.
	logic              sum_neg;
	logic [ERR_W-1:0]  mag_c;

	always_comb begin
		sum_neg = sum_q[SUM_W-1];
		if (cnt_q == '0)
			mag_c = '0;
		else if (sum_neg)
			mag_c = (quot > ERR_NEG_LIM) ? ERR_NEG_LIM[ERR_W-1:0] : quot[ERR_W-1:0];
		else
			mag_c = (quot > ERR_POS_LIM) ? ERR_POS_LIM[ERR_W-1:0] : quot[ERR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.take_err) begin
			mag_q <= mag_c;
			e_q   <= sum_neg ? ((~mag_c) + ERR_W'(1)) : mag_c;
		end
	end

	// Integrator: variable-speed rule, then the integral gain rule.
	logic signed [INTEG_W-1:0] integ_q;
	logic signed [ERR_W-1:0]   last_q;
	logic [Q2_W-1:0]           q2_mag;
	logic signed [INTEG_W+1:0] q2_s, vs_sum, gain_sum;
	logic                      in_window;

	always_comb begin
		q2_mag    = quot[Q2_W-1:0];
		q2_s      = e_q[ERR_W-1] ? -(INTEG_W+2)'(q2_mag) : (INTEG_W+2)'(q2_mag);
		vs_sum    = (INTEG_W+2)'(integ_q) + q2_s;
		gain_sum  = (INTEG_W+2)'(integ_q) + (INTEG_W+2)'(e_q);
		in_window = mag_q < {1'b0, window_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
		end else if (cmd.integ_vs) begin
			integ_q <= in_window ? sat_integ(vs_sum) : '0;
		end else if (cmd.integ_gain) begin
			integ_q <= (gain_i_q != '0) ? sat_integ(gain_sum) : '0;
		end
	end

	// Shared multiplier with a product register, then the accumulator.
	logic signed [ERR_W:0]     err_diff;
	logic signed [GAIN_W-1:0]  mul_a;
	logic signed [INTEG_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [ACC_W-1:0]   acc_q, rnd;
	logic signed [DRV_W-1:0]   drv_q;

	always_comb begin
		err_diff = (ERR_W+1)'(e_q) - (ERR_W+1)'(last_q);
		case (cmd.mul_sel)
			MUL_SEL_P: begin
				mul_a = gain_p_q;
				mul_b = INTEG_W'(e_q);
			end
			MUL_SEL_I: begin
				mul_a = gain_i_q;
				mul_b = integ_q;
			end
			MUL_SEL_D: begin
				mul_a = gain_d_q;
				mul_b = INTEG_W'(err_diff);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		rnd = acc_q + (acc_q[ACC_W-1] ? BIAS : ACC_W'(0));
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_s1 <= PROD_W'(mul_a) * PROD_W'(mul_b);
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_s1);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_s1);
			default: begin
			end
		endcase
		if (cmd.round)
			drv_q <= DRV_W'(rnd >>> FRAC_BITS);
	end

	// Clamp and result register.
	logic signed [DRV_W-1:0]   drv_hi, drv_lo;
	logic signed [DRIVE_W-1:0] drv_clamped;
	logic                      out_free, out_load;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic signed [ERR_W-1:0]   err_out_q;
	logic                      lost_q;

	always_comb begin
		drv_hi = DRV_W'(drive_max_q);
		drv_lo = DRV_W'(drive_min_q);
		if (drv_q > drv_hi)
			drv_clamped = drive_max_q;
		else if (drv_q < drv_lo)
			drv_clamped = drive_min_q;
		else
			drv_clamped = drv_q[DRIVE_W-1:0];
		out_free = !out_valid_q || !result_stall;
		out_load = cmd.finish && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				last_q      <= e_q;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			drive_q   <= drv_clamped;
			err_out_q <= e_q;
			lost_q    <= (cnt_q == '0);
		end
	end

	assign status.div_done = div_done;
	assign status.out_free = out_free;
	assign result_valid    = out_valid_q;
	assign drive           = drive_q;
	assign position_error  = err_out_q;
	assign line_lost       = lost_q;

endmodule

@@ rtl/core/lsps_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor PID steering: controller
// Walks one word through the two divisions, the integrator update and the
// three multiply-accumulate steps, then hands it to the result register.
// ----------------------------------------------------------------------------
module lsps_controller (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sensor_valid,
	output logic              sensor_stall,
	input  lsps_pkg::status_t status,
	output lsps_pkg::cmd_t    cmd
);

	import lsps_pkg::*;

	typedef enum logic [11:0] {
		ST_IDLE       = 12'b0000_0000_0001,
		ST_DIV_E_GO   = 12'b0000_0000_0010,
		ST_DIV_E_WAIT = 12'b0000_0000_0100,
		ST_TAKE_E     = 12'b0000_0000_1000,
		ST_DIV_Q_GO   = 12'b0000_0001_0000,
		ST_DIV_Q_WAIT = 12'b0000_0010_0000,
		ST_INTEG_VS   = 12'b0000_0100_0000,
		ST_INTEG_GAIN = 12'b0000_1000_0000,
		ST_MUL_I      = 12'b0001_0000_0000,
		ST_ACC        = 12'b0010_0000_0000,
		ST_ROUND      = 12'b0100_0000_0000,
		ST_FINISH     = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = sensor_valid;
				if (sensor_valid)
					state_d = ST_DIV_E_GO;
			end
			ST_DIV_E_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_ERR;
				state_d       = ST_DIV_E_WAIT;
			end
			ST_DIV_E_WAIT: begin
				cmd.div_sel = DIV_SEL_ERR;
				if (status.div_done)
					state_d = ST_TAKE_E;
			end
			ST_TAKE_E: begin
				cmd.take_err = 1'b1;
				state_d      = ST_DIV_Q_GO;
			end
			ST_DIV_Q_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_SEL_INTEG;
				state_d       = ST_DIV_Q_WAIT;
			end
			ST_DIV_Q_WAIT: begin
				cmd.div_sel = DIV_SEL_INTEG;
				if (status.div_done)
					state_d = ST_INTEG_VS;
			end
			ST_INTEG_VS: begin
				// The proportional product does not need the integrator.
				cmd.div_sel  = DIV_SEL_INTEG;
				cmd.integ_vs = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_SEL_P;
				state_d      = ST_INTEG_GAIN;
			end
			ST_INTEG_GAIN: begin
				cmd.integ_gain = 1'b1;
				cmd.mul_en     = 1'b1;
				cmd.mul_sel    = MUL_SEL_D;
				cmd.acc_op     = ACC_LOAD;
				state_d        = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SEL_I;
				cmd.acc_op  = ACC_ADD;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.finish = 1'b1;
				if (status.out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign sensor_stall = (state_q != ST_IDLE);

endmodule

@@ rtl/core/line_sensor_pid_steering_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor PID steering unit
// Positional PID steering controller with variable-speed integration, fed
// by a row of line-sensor flags.
//
// Channel  Dir  Handshake                   Payload
// sensor   in   sensor_valid / sensor_stall sensor_bits[7:0]
// result   out  result_valid / result_stall drive[23:0], position_error[15:0],
//                                           line_lost
// config   in   cfg_valid / cfg_ready       cfg_index[2:0], cfg_data[23:0]
//
// One word is worked through to its final step before the next word can be
// accepted. The two divisions run one after the other in the shared
// two-bit-per-cycle divider.
// A new sensor word is taken while an earlier result still waits; the block
// holds in its last step only if that result has not been taken yet.
// Reset loads the register defaults and clears the integrator and the
// previous error. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module line_sensor_pid_steering_unit #(
	parameter int NUM_SENSORS = lsps_pkg::DEF_NUM_SENSORS,
	parameter int FRAC_BITS   = lsps_pkg::DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sensor_valid,
	output logic                                sensor_stall,
	input  logic [lsps_pkg::IN_W-1:0]           sensor_bits,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [lsps_pkg::DRIVE_W-1:0] drive,
	output logic signed [lsps_pkg::ERR_W-1:0]   position_error,
	output logic                                line_lost,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lsps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsps_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import lsps_pkg::*;

	cmd_t    cmd;
	status_t status;
	cfg_wr_t cfg_wr;

	// The register file takes a write in any cycle.
	assign cfg_ready    = 1'b1;
	assign cfg_wr.en    = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	lsps_controller u_controller (
		.clk         (clk),
		.arst_n      (arst_n),
		.sensor_valid(sensor_valid),
		.sensor_stall(sensor_stall),
		.status      (status),
		.cmd         (cmd)
	);

	lsps_datapath #(
		.NUM_SENSORS(NUM_SENSORS),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg           (cfg_wr),
		.sensor_bits   (sensor_bits),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.drive         (drive),
		.position_error(position_error),
		.line_lost     (line_lost)
	);

	// A result appears only out of the final step.
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.finish))
		else $error("result word appeared outside the final step");

	// A lost line always reports a centered error.
	a_lost_means_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && line_lost |-> position_error == '0)
		else $error("line lost with nonzero position error");

	// An accepted sensor word keeps the input side busy.
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> sensor_stall)
		else $error("sensor input not stalled after a word was taken");

	// A finished word lands in the result register.
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && status.out_free |=> result_valid)
		else $error("finished word not presented");

endmodule

@@ tb/tb_line_sensor_pid_steering_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor PID steering unit: self-checking testbench
// Sends sensor words through the stall handshake and keeps a bit-exact
// steering predictor, with its own gain, clamp and integrator state. Each
// result word is checked field by field against the oldest prediction.
// The registers are reprogrammed between phases while the block is idle.
// A short directed part covers the extremes, line loss, the window edge,
// a zero integral gain and crossed clamps. Random phases follow, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_line_sensor_pid_steering_unit;
	import lsps_pkg::*;

	localparam int LIMIT_CYCLES  = 800000;
	localparam int DRAIN_CYCLES  = 80;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_WORDS   = 115;
	localparam longint ONE_Q     = longint'(1) << DEF_FRAC_BITS;

	// Indexes past the last register: writes to them must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [ERR_W-1:0]   err;
		logic                      lost;
	} steer_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sensor_valid = 1'b0;
	logic sensor_stall;
	logic [IN_W-1:0] sensor_bits = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [DRIVE_W-1:0] drive;
	logic signed [ERR_W-1:0] position_error;
	logic line_lost;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register copies as the block should hold them.
	logic signed [GAIN_W-1:0]  kp_m   = RST_GAIN_P;
	logic signed [GAIN_W-1:0]  ki_m   = RST_GAIN_I;
	logic signed [GAIN_W-1:0]  kd_m   = RST_GAIN_D;
	logic signed [DRIVE_W-1:0] dmax_m = RST_DRIVE_MAX;
	logic signed [DRIVE_W-1:0] dmin_m = RST_DRIVE_MIN;
	logic [WIN_W-1:0]          win_m  = RST_WINDOW;

	// Controller state of the predictor.
	longint prev_err_m = 0;
	longint integ_m = 0;

	logic [IN_W-1:0] pending_words[$];
	steer_result_t steer_results_q[$];
	int mismatches = 0;
	int gap_left = 0;
	int stall_left = 0;
	bit calm = 1'b0;

	line_sensor_pid_steering_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.sensor_valid  (sensor_valid),
		.sensor_stall  (sensor_stall),
		.sensor_bits   (sensor_bits),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.drive         (drive),
		.position_error(position_error),
		.line_lost     (line_lost),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic longint sat_int32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// Register value of a given width: extremes, zero, small or full random.
	// Bits above the width stay random since the block must ignore them.
	function automatic logic [CFG_DATA_W-1:0] rand_reg_value(input int w);
		logic [CFG_DATA_W-1:0] v;
		logic [CFG_DATA_W-1:0] mask;
		int r;
		v = CFG_DATA_W'($urandom);
		mask = (24'h1 << w) - 24'h1;
		r = $urandom_range(0, 9);
		case (r)
			0: v = (v & ~mask) | (mask >> 1);
			1: v = (v & ~mask) | ((mask >> 1) + 24'h1);
			2: v = v & ~mask;
			3, 4, 5: v = (v & ~mask) | (24'($signed($urandom_range(0, 2048)) - 1024) & mask);
			default: ;
		endcase
		return v;
	endfunction

	// Steering step: position error, integrator update and clamped drive.
	task automatic predict_word(input logic [IN_W-1:0] bits);
		longint wsum;
		longint cnt;
		longint e;
		longint mag;
		longint drv;
		steer_result_t res;
		wsum = 0;
		cnt = 0;
		for (int i = 0; i < DEF_NUM_SENSORS; i++) begin
			if (bits[i]) begin
				wsum += longint'(2 * i - (DEF_NUM_SENSORS - 1)) * 10;
				cnt++;
			end
		end
		e = (cnt == 0) ? 0 : (wsum * ONE_Q) / cnt;
		if (e > 32767)
			e = 32767;
		else if (e < -32768)
			e = -32768;
		mag = (e < 0) ? -e : e;

		// Variable-speed integration inside the window, cleared outside it.
		if (mag < longint'(win_m))
			integ_m = sat_int32(integ_m + (5 * e * ONE_Q) / (mag + 5 * ONE_Q));
		else
			integ_m = 0;
		if (ki_m != 0)
			integ_m = sat_int32(integ_m + e);
		else
			integ_m = 0;

		drv = longint'(kp_m) * e + longint'(ki_m) * integ_m
			+ longint'(kd_m) * (e - prev_err_m);
		drv = drv / ONE_Q;
		// The upper clamp is tested first, so it wins when the limits cross.
		if (drv > longint'(dmax_m))
			drv = longint'(dmax_m);
		else if (drv < longint'(dmin_m))
			drv = longint'(dmin_m);
		prev_err_m = e;

		res.drive = drv[DRIVE_W-1:0];
		res.err = e[ERR_W-1:0];
		res.lost = (cnt == 0);
		steer_results_q.push_back(res);
	endtask

	// Sensor driver: presents queued words, holds them while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_valid <= 1'b0;
			sensor_bits <= '0;
			gap_left <= 0;
		end else begin
			if (sensor_valid && !sensor_stall)
				predict_word(sensor_bits);
			if (!(sensor_valid && sensor_stall)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					sensor_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					sensor_valid <= 1'b1;
					sensor_bits <= pending_words.pop_front();
					gap_left <= pick_gap();
				end else begin
					sensor_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each taken word and stalls at random.
	always @(posedge clk or negedge arst_n) begin : result_mon
		steer_result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (steer_results_q.size() == 0) begin
					$display("%0t: unexpected result word drive=%0d err=%0d lost=%0b",
						$time, drive, position_error, line_lost);
					mismatches++;
				end else begin
					want = steer_results_q.pop_front();
					if (want.drive !== drive) begin
						$display("%0t: drive expected %0d actual %0d",
							$time, want.drive, drive);
						mismatches++;
					end
					if (want.err !== position_error) begin
						$display("%0t: position_error expected %0d actual %0d",
							$time, want.err, position_error);
						mismatches++;
					end
					if (want.lost !== line_lost) begin
						$display("%0t: line_lost expected %0b actual %0b",
							$time, want.lost, line_lost);
						mismatches++;
					end
				end
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				result_stall <= 1'b0;
				stall_left <= pick_gap();
			end
		end
	end

	// One register write, mirrored into the predictor on acceptance.
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_GAIN_P: kp_m = data[GAIN_W-1:0];
			CFG_GAIN_I: ki_m = data[GAIN_W-1:0];
			CFG_GAIN_D: kd_m = data[GAIN_W-1:0];
			CFG_DRIVE_MAX: dmax_m = data[DRIVE_W-1:0];
			CFG_DRIVE_MIN: dmin_m = data[DRIVE_W-1:0];
			CFG_WINDOW: win_m = data[WIN_W-1:0];
			default: ;
		endcase
	endtask

	// Block is idle once every queued word went in and every result came out.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_words.size() != 0 || sensor_valid || steer_results_q.size() != 0);
	endtask

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [IN_W-1:0] w;
		int r;
		int len;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: line loss, outer sensors, centered and spread lines.
		pending_words = '{8'h00, 8'h01, 8'h80, 8'h18, 8'hFF, 8'h03, 8'hC0,
			8'h00, 8'h55, 8'hAA};
		wait_idle();

		// Zero integral gain, errors right at the window edge, crossed clamps.
		cfg_write(CFG_GAIN_I, 24'h000000);
		cfg_write(CFG_GAIN_D, 24'h0000C8);
		cfg_write(CFG_WINDOW, 24'h000A00);
		cfg_write(CFG_DRIVE_MAX, -24'sd1000);
		cfg_write(CFG_DRIVE_MIN, 24'sd1000);
		pending_words = '{8'h10, 8'h08, 8'h19, 8'h00, 8'h80, 8'h01};
		wait_idle();

		// Extreme gains and clamps, window just above the smallest error.
		cfg_write(CFG_GAIN_P, 24'hFF7FFF);
		cfg_write(CFG_GAIN_I, 24'h008000);
		cfg_write(CFG_GAIN_D, 24'h808000);
		cfg_write(CFG_DRIVE_MAX, 24'h7FFFFF);
		cfg_write(CFG_DRIVE_MIN, 24'h800000);
		cfg_write(CFG_WINDOW, 24'hFF0A01);
		cfg_write(CFG_SPARE_A, 24'h000000);
		cfg_write(CFG_SPARE_B, 24'hFFFFFF);
		pending_words = '{8'h10, 8'h10, 8'h08, 8'h01, 8'h80, 8'h01, 8'h80, 8'hFF};
		wait_idle();

		// Random phases: new settings each time, mostly plausible line shapes.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			calm = (ph % 3 == 2);
			if (ph % 4 == 0) begin
				cfg_write(CFG_GAIN_P, 24'($urandom_range(0, 2048)));
				cfg_write(CFG_GAIN_I, 24'($urandom_range(1, 40)));
				cfg_write(CFG_GAIN_D, 24'($urandom_range(0, 1024)));
				cfg_write(CFG_WINDOW, 24'($urandom_range(0, 20000)));
			end else begin
				cfg_write(CFG_GAIN_P, rand_reg_value(GAIN_W));
				cfg_write(CFG_GAIN_I, rand_reg_value(GAIN_W));
				cfg_write(CFG_GAIN_D, rand_reg_value(GAIN_W));
				cfg_write(CFG_WINDOW, rand_reg_value(WIN_W));
			end
			cfg_write(CFG_DRIVE_MAX, rand_reg_value(DRIVE_W));
			cfg_write(CFG_DRIVE_MIN, rand_reg_value(DRIVE_W));
			if ($urandom_range(0, 2) == 0)
				cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
					CFG_DATA_W'($urandom));
			for (int k = 0; k < PHASE_WORDS; k++) begin
				r = $urandom_range(0, 9);
				if (r < 4) begin
					w = IN_W'($urandom);
				end else if (r < 8) begin
					len = $urandom_range(1, 3);
					w = ((8'h1 << len) - 8'h1) << $urandom_range(0, IN_W - len);
				end else if (r == 8) begin
					w = 8'h00;
				end else begin
					w = $urandom_range(0, 1) ? 8'hFF : (8'h1 << $urandom_range(0, 7));
				end
				pending_words.push_back(w);
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && steer_results_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
